// ----- rtl/mxw_pkg.sv -----
// Shared widths and constants for the multiply-xor Weyl generator.
package mxw_pkg;

    localparam int HALF_W = 16;
    localparam int WORD_W = 2 * HALF_W;
    localparam int SEED_W = 3 * HALF_W;

    localparam logic [HALF_W-1:0] WEYL_STEP = 16'h9E37;

    localparam int WARMUP_WORDS_DEFAULT = 8;

endpackage

// ----- rtl/mul_xor_weyl_prng16.sv -----
// Top level of the 16-bit multiply-xor pseudo-random generator with a Weyl counter.
//
// The generator holds three 16-bit words: a mix word, a sum word and a Weyl counter.
// A single 16x16 multiplier followed by one add stage forms the step unit.
// A small sequencer drives that unit once per clock, save while a final step is held.
// Every request on the input channel runs two steps and returns one 32-bit word on the
// output channel. The first step's output sits in bits 15:0 and the second's in bits 31:16.
// A request with reseed set first loads the state from the 48-bit seed register.
// Bits 15:0 of the seed go to the mix word, 31:16 to the sum word and 47:32 to the
// Weyl word. The block then runs 2*WARMUP_WORDS discarded steps before the two
// steps that produce the word.
// A plain request therefore runs its two steps after acceptance, then the result is registered.
// A reseed request runs 2 + 2*WARMUP_WORDS steps. The multiplier is the one shared unit.
// In the cycle of an item's last step, a new request may already be accepted.
// The block thus takes the next request before it is done with the last one while the output keeps up.
// The result is held in an output register until it is taken. A full output
// register stalls only the final step of the next item.
// The seed register is written through its own channel, which is always ready.
// A write does not touch the running state until the next reseed request.
module mul_xor_weyl_prng16 #(
    parameter int WARMUP_WORDS = mxw_pkg::WARMUP_WORDS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      reseed,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mxw_pkg::WORD_W-1:0] random_word,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [mxw_pkg::SEED_W-1:0] seed_value
);

    localparam int HW        = mxw_pkg::HALF_W;
    localparam int STEPS_MAX = 2 * WARMUP_WORDS + 2;
    localparam int CNT_W     = $clog2(STEPS_MAX + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          remain_reg, remain_next;
    logic [HW-1:0]             mix_reg, mix_next;
    logic [HW-1:0]             sum_reg, sum_next;
    logic [HW-1:0]             weyl_reg, weyl_next;
    logic [HW-1:0]             lo_reg, lo_next;
    logic [mxw_pkg::SEED_W-1:0] seed_reg, seed_next;
    logic                      out_valid_reg, out_valid_next;
    logic [mxw_pkg::WORD_W-1:0] random_word_reg, random_word_next;

    // Step unit: one multiply, then the Weyl advance and the sum/xor update.
    logic [2*HW-1:0] prod;
    logic [HW-1:0]   weyl_step;
    logic [HW-1:0]   sum_step;
    logic [HW-1:0]   mix_step;

    logic            running;
    logic            last_step;
    logic            out_blocked;
    logic            step_go;
    logic            in_fire;

    always_comb
    begin
        prod      = mix_reg * sum_reg;
        weyl_step = weyl_reg + mxw_pkg::WEYL_STEP;
        sum_step  = sum_reg + prod[2*HW-1:HW] + weyl_step;
        mix_step  = prod[HW-1:0] ^ sum_step;
    end

    assign running     = (state_reg == ST_RUN);
    assign last_step   = (remain_reg == CNT_W'(1));
    assign out_blocked = out_valid_reg && !out_ready;
    // Hold the final step while the previous word still waits at the output.
    assign step_go     = running && !(last_step && out_blocked);
    // Take a new request when idle, or alongside the current item's final step.
    assign in_ready    = !running || (step_go && last_step);
    assign in_fire     = in_valid && in_ready;
    assign cfg_ready   = 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        remain_next      = remain_reg;
        mix_next         = mix_reg;
        sum_next         = sum_reg;
        weyl_next        = weyl_reg;
        lo_next          = lo_reg;
        seed_next        = seed_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        random_word_next = random_word_reg;

        if (cfg_valid)
        begin
            seed_next = seed_value;
        end

        if (step_go)
        begin
            mix_next    = mix_step;
            sum_next    = sum_step;
            weyl_next   = weyl_step;
            remain_next = remain_reg - CNT_W'(1);
            // Even count left: this is the first step of a pair, keep its output.
            if (!remain_reg[0])
            begin
                lo_next = mix_step;
            end
            if (last_step)
            begin
                out_valid_next   = 1'b1;
                random_word_next = {mix_step, lo_reg};
                state_next       = ST_IDLE;
            end
        end

        if (in_fire)
        begin
            state_next = ST_RUN;
            if (reseed)
            begin
                mix_next    = seed_reg[HW-1:0];
                sum_next    = seed_reg[2*HW-1:HW];
                weyl_next   = seed_reg[3*HW-1:2*HW];
                remain_next = CNT_W'(STEPS_MAX);
            end
            else
            begin
                remain_next = CNT_W'(2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            remain_reg      <= '0;
            mix_reg         <= '0;
            sum_reg         <= '0;
            weyl_reg        <= '0;
            lo_reg          <= '0;
            seed_reg        <= '0;
            out_valid_reg   <= 1'b0;
            random_word_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            remain_reg      <= remain_next;
            mix_reg         <= mix_next;
            sum_reg         <= sum_next;
            weyl_reg        <= weyl_next;
            lo_reg          <= lo_next;
            seed_reg        <= seed_next;
            out_valid_reg   <= out_valid_next;
            random_word_reg <= random_word_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign random_word = random_word_reg;

endmodule

// ----- rtl/mxw_checker.sv -----
// Port-level checks for the multiply-xor Weyl generator, bound to its top level.
module mxw_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [mxw_pkg::WORD_W-1:0] random_word
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(random_word))
        else $error("output word changed while stalled");

    // An accepted request keeps the block busy for at least one more step.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new request taken one cycle after another");

    // A request needs two steps, so no fresh word shows up in the cycle of its second step.
    a_no_early_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 !$rose(out_valid))
        else $error("word produced too early after a request");

endmodule

bind mul_xor_weyl_prng16 mxw_checker u_mxw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_word (random_word)
);
